// ===== sv/salts_pkg.sv =====
package salts_pkg;

    // widths of the configuration fields and ports
    localparam int SET_CNT_W  = 7;
    localparam int WAY_CNT_W  = 4;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 8;
    localparam int OUT_DATA_W = 8;
    localparam int STAMP_W    = 32;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SET_COUNT = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WAY_COUNT = 4'd1;

    // reset values of the configuration registers
    localparam logic [SET_CNT_W-1:0] SET_COUNT_RST = 7'd16;
    localparam logic [WAY_CNT_W-1:0] WAY_COUNT_RST = 4'd4;

    typedef struct packed {
        logic start;
    } div_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

// ===== sv/salts_ram.sv =====
module salts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== sv/salts_div_unit.sv =====
module salts_div_unit #(
    parameter int ADDR_BITS = 32,
    parameter int SET_W     = 7
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  salts_pkg::div_ctrl_t  ctrl,
    input  logic [ADDR_BITS-1:0]  dividend,
    input  logic [SET_W-1:0]      divisor,
    output salts_pkg::div_stat_t  stat,
    output logic [ADDR_BITS-1:0]  quotient,
    output logic [SET_W-1:0]      remainder
);

    import salts_pkg::*;

    localparam int CNT_W = $clog2(ADDR_BITS + 1);

    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic                 done_reg, done_next;
    logic [ADDR_BITS-1:0] shift_reg, shift_next;
    logic [SET_W-1:0]     rem_reg, rem_next;
    logic [SET_W-1:0]     dsor_reg, dsor_next;
    logic [SET_W:0]       trial;
    logic [SET_W:0]       diff;
    logic                 ge;

    // one restoring step per cycle: the quotient bit shifts in behind the dividend
    assign trial = {rem_reg, shift_reg[ADDR_BITS-1]};
    assign diff  = trial - {1'b0, dsor_reg};
    assign ge    = trial >= {1'b0, dsor_reg};

    always_comb
    begin
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        shift_next = shift_reg;
        rem_next   = rem_reg;
        dsor_next  = dsor_reg;
        if (ctrl.start)
        begin
            cnt_next   = CNT_W'(ADDR_BITS);
            shift_next = dividend;
            rem_next   = '0;
            dsor_next  = divisor;
        end
        else if (cnt_reg != '0)
        begin
            cnt_next   = cnt_reg - 1'b1;
            done_next  = (cnt_reg == CNT_W'(1));
            shift_next = {shift_reg[ADDR_BITS-2:0], ge};
            rem_next   = ge ? diff[SET_W-1:0] : trial[SET_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
        rem_reg   <= rem_next;
        dsor_reg  <= dsor_next;
    end

    assign stat.busy = (cnt_reg != '0);
    assign stat.done = done_reg;
    assign quotient  = shift_reg;
    assign remainder = rem_reg;

endmodule

// ===== sv/set_assoc_lru_tag_store_top.sv =====
// Tag store of a set-associative cache with LRU replacement. Each item on s_axis is one
// address; the set is the address modulo the configured set count and the tag is the
// quotient. One item comes back on m_axis per address, with bit 0 of tdata set on a hit.
// A bit-serial divider produces set and tag one bit a cycle, then the tag RAM (one write
// port, one read port) is read one way a cycle, oldest stamp tracked on the fly, and the
// chosen way is written back. s_axis_tready is high only between items, while a finished
// result may still wait in the output register. After reset all MAX_SETS * MAX_WAYS RAM
// entries (512 with the defaults) are swept clean before the first item is taken;
// configuration writes are taken at any time but must only happen while idle.
// set_count and way_count of zero act as one and are capped at MAX_SETS and MAX_WAYS.
module set_assoc_lru_tag_store_top #(
    parameter int MAX_SETS  = 64,
    parameter int MAX_WAYS  = 8,
    parameter int ADDR_BITS = 32
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    s_axis_tvalid,
    output logic                                    s_axis_tready,
    // [ADDR_BITS-1:0] address
    input  logic [((ADDR_BITS + 7) / 8) * 8 - 1:0]  s_axis_tdata,
    output logic                                    m_axis_tvalid,
    input  logic                                    m_axis_tready,
    // [0] hit
    output logic [salts_pkg::OUT_DATA_W-1:0]        m_axis_tdata,
    input  logic                                    cfg_valid,
    output logic                                    cfg_ready,
    input  logic [salts_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [salts_pkg::CFG_DATA_W-1:0]        cfg_data
);

    import salts_pkg::*;

    localparam int ENTRIES = MAX_SETS * MAX_WAYS;
    localparam int ENT_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int SET_W   = $clog2(MAX_SETS + 1);
    localparam int WAY_W   = $clog2(MAX_WAYS + 1);
    localparam int MEM_W   = 1 + ADDR_BITS + STAMP_W;

    typedef enum logic [4:0] {
        ST_CLEAR = 5'b00001,
        ST_IDLE  = 5'b00010,
        ST_DIV   = 5'b00100,
        ST_SCAN  = 5'b01000,
        ST_WRITE = 5'b10000
    } state_t;

    state_t               state_reg, state_next;
    logic [SET_CNT_W-1:0] set_count_reg;
    logic [WAY_CNT_W-1:0] way_count_reg;
    logic [STAMP_W-1:0]   ref_cnt_reg, ref_cnt_next;
    logic [ENT_W-1:0]     clr_idx_reg, clr_idx_next;
    logic [WAY_W-1:0]     ways_reg, ways_next;
    logic [WAY_W-1:0]     iss_way_reg, iss_way_next;
    logic                 chk_vld_reg, chk_vld_next;
    logic [WAY_W-1:0]     chk_way_reg, chk_way_next;
    logic                 have_old_reg, have_old_next;
    logic [STAMP_W-1:0]   old_stamp_reg, old_stamp_next;
    logic [WAY_W-1:0]     victim_reg, victim_next;
    logic                 hit_reg, hit_next;
    logic [ADDR_BITS-1:0] tag_reg, tag_next;
    logic [ENT_W-1:0]     base_reg, base_next;
    logic                 out_valid_reg, out_valid_next;
    logic                 out_hit_reg, out_hit_next;

    logic [SET_W-1:0]     sets_eff;
    logic [WAY_W-1:0]     ways_eff;
    logic                 in_acc;
    logic                 out_free;

    div_ctrl_t            div_ctrl;
    div_stat_t            div_stat;
    logic [ADDR_BITS-1:0] div_quot;
    logic [SET_W-1:0]     div_rem;

    logic                 mem_we;
    logic [ENT_W-1:0]     mem_waddr;
    logic [MEM_W-1:0]     mem_wdata;
    logic [ENT_W-1:0]     mem_raddr;
    logic [MEM_W-1:0]     mem_rdata;
    logic                 rd_valid;
    logic [ADDR_BITS-1:0] rd_tag;
    logic [STAMP_W-1:0]   rd_stamp;

    // configuration
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            set_count_reg <= SET_COUNT_RST;
            way_count_reg <= WAY_COUNT_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_SET_COUNT: set_count_reg <= cfg_data[SET_CNT_W-1:0];
                REG_WAY_COUNT: way_count_reg <= cfg_data[WAY_CNT_W-1:0];
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        if (set_count_reg == '0)
            sets_eff = SET_W'(1);
        else if (int'(set_count_reg) > MAX_SETS)
            sets_eff = SET_W'(MAX_SETS);
        else
            sets_eff = SET_W'(set_count_reg);

        if (way_count_reg == '0)
            ways_eff = WAY_W'(1);
        else if (int'(way_count_reg) > MAX_WAYS)
            ways_eff = WAY_W'(MAX_WAYS);
        else
            ways_eff = WAY_W'(way_count_reg);
    end

    salts_div_unit #(
        .ADDR_BITS (ADDR_BITS),
        .SET_W     (SET_W)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (div_ctrl),
        .dividend  (s_axis_tdata[ADDR_BITS-1:0]),
        .divisor   (sets_eff),
        .stat      (div_stat),
        .quotient  (div_quot),
        .remainder (div_rem)
    );

    // entry word: valid, tag, stamp
    salts_ram #(
        .WIDTH (MEM_W),
        .DEPTH (ENTRIES)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign rd_valid = mem_rdata[MEM_W-1];
    assign rd_tag   = mem_rdata[STAMP_W +: ADDR_BITS];
    assign rd_stamp = mem_rdata[STAMP_W-1:0];

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign div_ctrl.start = in_acc;
    assign mem_raddr     = base_reg + ENT_W'(iss_way_reg);

    always_comb
    begin
        state_next     = state_reg;
        ref_cnt_next   = ref_cnt_reg;
        clr_idx_next   = clr_idx_reg;
        ways_next      = ways_reg;
        iss_way_next   = iss_way_reg;
        chk_vld_next   = 1'b0;
        chk_way_next   = chk_way_reg;
        have_old_next  = have_old_reg;
        old_stamp_next = old_stamp_reg;
        victim_next    = victim_reg;
        hit_next       = hit_reg;
        tag_next       = tag_reg;
        base_next      = base_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_hit_next   = out_hit_reg;
        mem_we         = 1'b0;
        mem_waddr      = base_reg + ENT_W'(victim_reg);
        mem_wdata      = {1'b1, tag_reg, ref_cnt_reg};

        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_we       = 1'b1;
                mem_waddr    = clr_idx_reg;
                mem_wdata    = '0;
                clr_idx_next = clr_idx_reg + 1'b1;
                if (clr_idx_reg == ENT_W'(ENTRIES - 1))
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    if (ref_cnt_reg != '1)
                        ref_cnt_next = ref_cnt_reg + 1'b1;
                    ways_next  = ways_eff;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_stat.done)
                begin
                    tag_next      = div_quot;
                    base_next     = ENT_W'(div_rem * MAX_WAYS);
                    iss_way_next  = '0;
                    have_old_next = 1'b0;
                    state_next    = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                // read of way n is issued while way n-1 is checked
                if (iss_way_reg < ways_reg)
                begin
                    iss_way_next = iss_way_reg + 1'b1;
                    chk_vld_next = 1'b1;
                    chk_way_next = iss_way_reg;
                end
                if (chk_vld_reg)
                begin
                    if (rd_valid && rd_tag == tag_reg)
                    begin
                        hit_next    = 1'b1;
                        victim_next = chk_way_reg;
                        state_next  = ST_WRITE;
                    end
                    else if (!rd_valid)
                    begin
                        // ways fill in order, so no later way can be valid
                        hit_next    = 1'b0;
                        victim_next = chk_way_reg;
                        state_next  = ST_WRITE;
                    end
                    else
                    begin
                        if (!have_old_reg || rd_stamp < old_stamp_reg)
                        begin
                            have_old_next  = 1'b1;
                            old_stamp_next = rd_stamp;
                            victim_next    = chk_way_reg;
                        end
                        if (chk_way_reg == ways_reg - 1'b1)
                        begin
                            hit_next   = 1'b0;
                            state_next = ST_WRITE;
                        end
                    end
                end
            end
            ST_WRITE:
            begin
                mem_we = 1'b1;
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_hit_next   = hit_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            ref_cnt_reg   <= '0;
            clr_idx_reg   <= '0;
            chk_vld_reg   <= 1'b0;
            have_old_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ref_cnt_reg   <= ref_cnt_next;
            clr_idx_reg   <= clr_idx_next;
            chk_vld_reg   <= chk_vld_next;
            have_old_reg  <= have_old_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ways_reg      <= ways_next;
        iss_way_reg   <= iss_way_next;
        chk_way_reg   <= chk_way_next;
        old_stamp_reg <= old_stamp_next;
        victim_reg    <= victim_next;
        hit_reg       <= hit_next;
        tag_reg       <= tag_next;
        base_reg      <= base_next;
        out_hit_reg   <= out_hit_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OUT_DATA_W - 1){1'b0}}, out_hit_reg};

endmodule

// ===== sv/salts_checker.sv =====
module salts_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              s_axis_tvalid,
    input logic                              s_axis_tready,
    input logic                              m_axis_tvalid,
    input logic                              m_axis_tready,
    input logic [salts_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);

    import salts_pkg::*;

    // the block is busy once it takes an item
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input still ready right after an item was taken");

    // a result cannot appear in the cycle right after an item is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !$rose(m_axis_tvalid))
        else $error("result appeared one cycle after an item was taken");

    // a new result is only produced while the input side is busy
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
        else $error("result appeared while the block was idle");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed or dropped");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[OUT_DATA_W-1:1] == '0)
        else $error("padding bits of result not zero");

endmodule

bind set_assoc_lru_tag_store_top salts_checker u_salts_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
